// ===== rtl/gat_pkg.sv =====
// shared types, constants and codes for the graph traversal engine
package gat_pkg;

    localparam int NODE_COUNT = 16;
    localparam int NODE_W     = 4;
    localparam int PTR_W      = NODE_W + 1;

    // command codes
    localparam logic [2:0] CMD_ADD_NODE    = 3'd0;
    localparam logic [2:0] CMD_REMOVE_NODE = 3'd1;
    localparam logic [2:0] CMD_ADD_EDGE    = 3'd2;
    localparam logic [2:0] CMD_REMOVE_EDGE = 3'd3;
    localparam logic [2:0] CMD_CLEAR       = 3'd4;
    localparam logic [2:0] CMD_CLEAR_EDGES = 3'd5;
    localparam logic [2:0] CMD_BFS         = 3'd6;
    localparam logic [2:0] CMD_DFS         = 3'd7;

    // status codes
    localparam logic [2:0] ST_NONE         = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd1;
    localparam logic [2:0] ST_EXISTS       = 3'd2;
    localparam logic [2:0] ST_ADJACENT     = 3'd3;
    localparam logic [2:0] ST_NOT_ADJACENT = 3'd4;

    typedef logic [NODE_W-1:0] node_id_t;

    typedef struct packed {
        logic [2:0] command;
        node_id_t   node_a;
        node_id_t   node_b;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        node_id_t   visited_node;
        logic       last;
    } out_word_t;

    // edit request from the sequencer to the graph store
    typedef struct packed {
        logic       en;
        logic [2:0] command;
        node_id_t   node_a;
        node_id_t   node_b;
    } edit_req_t;

endpackage

// ===== rtl/gat_graph.sv =====
// node-present bitmap and adjacency matrix with edit logic and row read
module gat_graph (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  gat_pkg::edit_req_t               edit,
    input  gat_pkg::node_id_t                row_addr,
    output logic [gat_pkg::NODE_COUNT-1:0]   row_data,
    output logic [gat_pkg::NODE_COUNT-1:0]   present,
    output logic [2:0]                       edit_status
);
    import gat_pkg::*;

    logic [NODE_COUNT-1:0] present_reg;
    logic [NODE_COUNT-1:0] adj_reg [NODE_COUNT];
    logic                  adj_bit;

    assign present  = present_reg;
    assign row_data = adj_reg[row_addr];
    assign adj_bit  = adj_reg[edit.node_a][edit.node_b];

    // status of an edit against the current graph
    always_comb begin
        edit_status = ST_NONE;
        case (edit.command)
            CMD_ADD_NODE: begin
                if (present_reg[edit.node_a]) edit_status = ST_EXISTS;
            end
            CMD_REMOVE_NODE: begin
                if (!present_reg[edit.node_a]) edit_status = ST_NOT_FOUND;
            end
            CMD_ADD_EDGE, CMD_REMOVE_EDGE: begin
                if (!present_reg[edit.node_a] || !present_reg[edit.node_b]) begin
                    edit_status = ST_NOT_FOUND;
                end else if (edit.command == CMD_ADD_EDGE) begin
                    if (adj_bit) edit_status = ST_ADJACENT;
                end else begin
                    if (!adj_bit) edit_status = ST_NOT_ADJACENT;
                end
            end
            default: edit_status = ST_NONE;
        endcase
    end

    // apply an edit that succeeded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            for (int i = 0; i < NODE_COUNT; i++) adj_reg[i] <= '0;
        end else if (edit.en && edit_status == ST_NONE) begin
            case (edit.command)
                CMD_ADD_NODE: begin
                    present_reg[edit.node_a] <= 1'b1;
                end
                CMD_REMOVE_NODE: begin
                    present_reg[edit.node_a] <= 1'b0;
                    for (int i = 0; i < NODE_COUNT; i++) begin
                        if (NODE_W'(i) == edit.node_a) adj_reg[i] <= '0;
                        else adj_reg[i][edit.node_a] <= 1'b0;
                    end
                end
                CMD_ADD_EDGE: begin
                    adj_reg[edit.node_a][edit.node_b] <= 1'b1;
                    adj_reg[edit.node_b][edit.node_a] <= 1'b1;
                end
                CMD_REMOVE_EDGE: begin
                    adj_reg[edit.node_a][edit.node_b] <= 1'b0;
                    adj_reg[edit.node_b][edit.node_a] <= 1'b0;
                end
                CMD_CLEAR: begin
                    present_reg <= '0;
                    for (int i = 0; i < NODE_COUNT; i++) adj_reg[i] <= '0;
                end
                CMD_CLEAR_EDGES: begin
                    for (int i = 0; i < NODE_COUNT; i++) adj_reg[i] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/gat_pick.sv =====
// neighbor scan unit: holds a candidate mask and yields its lowest id each cycle
module gat_pick (
    input  logic                             aclk,
    input  logic                             load,
    input  logic [gat_pkg::NODE_COUNT-1:0]   load_mask,
    input  logic                             take,
    output logic                             any,
    output gat_pkg::node_id_t                idx
);
    import gat_pkg::*;

    logic [NODE_COUNT-1:0] mask_reg;
    logic [NODE_COUNT-1:0] mask_next;

    // lowest set bit wins
    always_comb begin
        idx = '0;
        for (int i = NODE_COUNT - 1; i >= 0; i--) begin
            if (mask_reg[i]) idx = NODE_W'(i);
        end
    end

    assign any = |mask_reg;

    always_comb begin
        mask_next = mask_reg;
        if (load) mask_next = load_mask;
        else if (take) mask_next = mask_reg & ~(NODE_COUNT'(1) << idx);
    end

    always_ff @(posedge aclk) begin
        mask_reg <= mask_next;
    end

endmodule

// ===== rtl/graph_adjacency_traversal_engine_unit.sv =====
// top level: command sequencer, walk queue/stack and output register
// Edits: one result word, registered in the cycle after acceptance; one command per cycle
// while the receiver keeps up.
// Walks: for each visited node the sequencer passes through S_POP, stays in S_SCAN while it pushes
// each unvisited neighbor and leaves it when the row is done, then enters S_EMIT, which a receiver
// stall can hold. Not ready while a walk runs or while the output word is held.
// aresetn (synchronous, active low) empties the graph and returns the sequencer to idle.
module graph_adjacency_traversal_engine_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gat_pkg::in_word_t   s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output gat_pkg::out_word_t  m_word
);
    import gat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic                  stack_reg, stack_next;
    logic [PTR_W-1:0]      front_reg, front_next;
    logic [PTR_W-1:0]      back_reg, back_next;
    logic [NODE_COUNT-1:0] visited_reg, visited_next;
    node_id_t              cur_reg, cur_next;
    node_id_t              pend_reg [NODE_COUNT];
    logic                  m_valid_reg, m_valid_next;
    out_word_t             m_word_reg, m_word_next;

    logic                  accept;
    logic                  out_free;
    logic                  is_walk;
    logic                  push;
    logic                  empty;
    logic [PTR_W-1:0]      pop_addr;
    node_id_t              pop_node;
    edit_req_t             edit;
    logic [NODE_COUNT-1:0] row_data;
    logic [NODE_COUNT-1:0] present;
    logic [2:0]            edit_status;
    logic                  pick_any;
    node_id_t              pick_idx;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;

    always_comb begin
        case (s_word.command)
            CMD_BFS, CMD_DFS: is_walk = 1'b1;
            default:          is_walk = 1'b0;
        endcase
    end

    assign edit.en      = accept && !is_walk;
    assign edit.command = s_word.command;
    assign edit.node_a  = s_word.node_a;
    assign edit.node_b  = s_word.node_b;

    // queue pops at the front, stack at the top
    assign pop_addr = stack_reg ? (back_reg - 1'b1) : front_reg;
    assign pop_node = pend_reg[pop_addr[NODE_W-1:0]];
    assign empty    = stack_reg ? (back_reg == '0) : (front_reg == back_reg);
    assign push     = (state_reg == S_SCAN) && pick_any;

    gat_graph u_graph (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .edit        (edit),
        .row_addr    (pop_node),
        .row_data    (row_data),
        .present     (present),
        .edit_status (edit_status)
    );

    gat_pick u_pick (
        .aclk      (aclk),
        .load      (state_reg == S_POP),
        .load_mask (row_data & ~visited_reg),
        .take      (push),
        .any       (pick_any),
        .idx       (pick_idx)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        stack_next   = stack_reg;
        front_next   = front_reg;
        back_next    = back_reg;
        visited_next = visited_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (!is_walk) begin
                        m_valid_next = 1'b1;
                        m_word_next  = '{status: edit_status, visited_node: '0, last: 1'b1};
                    end else if (!present[s_word.node_a]) begin
                        m_valid_next = 1'b1;
                        m_word_next  = '{status: ST_NOT_FOUND, visited_node: '0, last: 1'b1};
                    end else begin
                        stack_next   = (s_word.command == CMD_DFS);
                        front_next   = '0;
                        back_next    = PTR_W'(1);
                        visited_next = NODE_COUNT'(1) << s_word.node_a;
                        state_next   = S_POP;
                    end
                end
            end
            S_POP: begin
                cur_next = pop_node;
                if (stack_reg) back_next = back_reg - 1'b1;
                else front_next = front_reg + 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (pick_any) begin
                    back_next    = back_reg + 1'b1;
                    visited_next = visited_reg | (NODE_COUNT'(1) << pick_idx);
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = '{status: ST_NONE, visited_node: cur_reg, last: empty};
                    state_next   = empty ? S_IDLE : S_POP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            front_reg   <= '0;
            back_reg    <= '0;
            visited_reg <= '0;
            stack_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            front_reg   <= front_next;
            back_reg    <= back_next;
            visited_reg <= visited_next;
            stack_reg   <= stack_next;
        end
    end

    // payload registers and pending-node store
    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_word_reg <= m_word_next;
        if (accept && is_walk) pend_reg[0] <= s_word.node_a;
        else if (push) pend_reg[back_reg[NODE_W-1:0]] <= pick_idx;
    end

endmodule
